### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the slot allocator checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("slot allocator assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("slot allocator forbidden condition seen");

`endif

### src/ffisa_pkg.sv
// ---------------------------------------------------------------------------
// ffisa_pkg
// types and constants shared by the slot allocator cells and top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffisa_pkg;

	localparam int TIME_W    = 32;
	localparam int CNT_W     = 32;
	localparam int SLOT_W    = 4;
	localparam int CFG_W     = 5;
	localparam int SLOTS_DEF = 16;
	localparam int CMP_W     = 9;   // holds any cell index up to 511 and the register

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	// request travelling down the cell chain
	typedef struct packed {
		logic              vld;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] end_time;
		logic              new_run;
		logic              last_of_run;
		logic              got;
		logic [SLOT_W-1:0] idx;
	} req_t;

endpackage

`default_nettype wire

### src/first_fit_interval_slot_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_interval_slot_allocator
// first-fit slot grant for interval requests over a systolic row of slot cells
// ---------------------------------------------------------------------------
//  channel   dir  handshake             contents
//  s_*       in   s_tvalid / s_tready   tdata start,end; tuser new_run; tlast last_of_run
//  m_*       out  m_tvalid / m_tready   tdata accepted,slot_index,count; tlast run_done
//  cfg_*     in   cfg_valid / cfg_ready slots_in_use (always ready)
//
//  one transaction per cycle unless m_* stalls; each request walks the chain of SLOTS cells,
//  registered in each cell, then the count stage feeding the output register
//  a request reaches cell j after its predecessor, which has already updated it
//  a stall on m_* freezes the whole chain; s_tready follows the output register
//  reset clears busy flags, the run count and all valid bits; slots_in_use resets to 16
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_interval_slot_allocator #(
	parameter int SLOTS = ffisa_pkg::SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] start_time, [63:32] end_time
	input  wire logic [0:0]  s_tuser,   // [0] new_run
	input  wire logic        s_tlast,   // last_of_run
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [0] accepted, [4:1] slot_index,
	                                    // [36:5] accepted_count, [39:37] zero
	output logic             m_tlast,   // run_done
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [ffisa_pkg::CFG_W-1:0] cfg_data
);
	import ffisa_pkg::*;

	logic [CFG_W-1:0]  slots_q;
	logic              adv;
	req_t              link [SLOTS+1];
	req_t              tail;

	logic              out_vld_q;
	logic              acc_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              last_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  base;
	logic [CNT_W-1:0]  total_nxt;

	// the whole chain moves unless a finished result is stuck at the output
	assign adv       = !out_vld_q || m_tready;
	assign s_tready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= CFG_RESET;
		end else if (cfg_valid) begin
			slots_q <= cfg_data;
		end
	end

	// head of the chain
	always_comb begin
		link[0].vld         = s_tvalid;
		link[0].start_time  = s_tdata[31:0];
		link[0].end_time    = s_tdata[63:32];
		link[0].new_run     = s_tuser[0];
		link[0].last_of_run = s_tlast;
		link[0].got         = 1'b0;
		link[0].idx         = '0;
	end

	// row of slot cells; one at or above slots_in_use grants nothing, but new_run clears its busy flag
	for (genvar j = 0; j < SLOTS; j++) begin : g_cell
		logic usable;
		assign usable = CMP_W'(j) < CMP_W'(slots_q);

		ffisa_cell #(
			.IDX(j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.usable (usable),
			.req_i  (link[j]),
			.req_o  (link[j+1])
		);
	end

	assign tail = link[SLOTS];

	// running count, restarted by new_run, saturating at all ones
	assign base      = tail.new_run ? '0 : total_q;
	assign total_nxt = (tail.got && (base != CNT_MAX)) ? base + CNT_W'(1) : base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			total_q   <= '0;
		end else if (adv) begin
			out_vld_q <= tail.vld;
			if (tail.vld) begin
				total_q <= total_nxt;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (adv && tail.vld) begin
			acc_q  <= tail.got;
			idx_q  <= tail.idx;
			cnt_q  <= total_nxt;
			last_q <= tail.last_of_run;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, cnt_q, idx_q, acc_q};
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

### src/ffisa_cell.sv
// ---------------------------------------------------------------------------
// ffisa_cell
// one slot: holds busy flag and end time, grants a passing request
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffisa_cell #(
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          usable,
	input  wire ffisa_pkg::req_t req_i,
	output ffisa_pkg::req_t    req_o
);
	import ffisa_pkg::*;

	logic              busy_q;
	logic [TIME_W-1:0] end_q;
	logic              vld_s1;
	req_t              pay_s1;
	req_t              pay_nxt;
	logic              hit;

	// a new run sees this slot as free
	assign hit = req_i.vld && !req_i.got && usable &&
		(!busy_q || req_i.new_run || (req_i.start_time > end_q));

	// request as it leaves this cell, marked as granted here on a hit
	always_comb begin
		pay_nxt = req_i;
		if (hit) begin
			pay_nxt.got = 1'b1;
			pay_nxt.idx = SLOT_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_i.vld;
			if (hit) begin
				busy_q <= 1'b1;
			end else if (req_i.vld && req_i.new_run) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_s1 <= pay_nxt;
			if (hit) begin
				end_q <= req_i.end_time;
			end
		end
	end

	always_comb begin
		req_o     = pay_s1;
		req_o.vld = vld_s1;
	end

endmodule

`default_nettype wire

### src/ffisa_checker.sv
// ---------------------------------------------------------------------------
// ffisa_checker
// port-level checks on the slot allocator, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ffisa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	// a stalled result stays offered and unchanged
	`ASSERT_ALWAYS(a_hold_vld, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid)
	`ASSERT_ALWAYS(a_hold_data, clk, arst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata))

	// refused requests report slot zero
	`ASSERT_NEVER(a_refused_idx, clk, arst_n, m_tvalid && !m_tdata[0] && (m_tdata[4:1] != 4'd0))

	// a granted request has been counted, so the run count cannot read zero
	`ASSERT_NEVER(a_grant_cnt, clk, arst_n, m_tvalid && m_tdata[0] && (m_tdata[36:5] == 32'd0))

endmodule

bind first_fit_interval_slot_allocator ffisa_checker u_ffisa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
